### rtl/core/u8cb_pkg.sv
// Shared constants for the mapped UTF-8 to raw byte decoder.
package u8cb_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned NEED_W   = 2;
    localparam int unsigned HIDDEN_W = 7;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

    // Printable ranges that map to themselves
    localparam logic [CP_W-1:0] PRINT_A_LO = 21'h00021;
    localparam logic [CP_W-1:0] PRINT_A_HI = 21'h0007E;
    localparam logic [CP_W-1:0] PRINT_B_LO = 21'h000A1;
    localparam logic [CP_W-1:0] PRINT_B_HI = 21'h000AC;
    localparam logic [CP_W-1:0] PRINT_C_LO = 21'h000AE;
    localparam logic [CP_W-1:0] PRINT_C_HI = 21'h000FF;

    // Code points 256..323 stand for the hidden bytes in order
    localparam logic [CP_W-1:0]     HIDDEN_BASE  = 21'd256;
    localparam logic [CP_W-1:0]     HIDDEN_END   = 21'd324;
    localparam logic [HIDDEN_W-1:0] HIDDEN_LOW_N = 7'd33;
    localparam logic [HIDDEN_W-1:0] HIDDEN_MID_N = 7'd67;
    localparam logic [BYTE_W-1:0]   HIDDEN_MID_OFS = 8'h5E;
    localparam logic [BYTE_W-1:0]   HIDDEN_SHY   = 8'hAD;

    // Lead byte masks
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

    // Result travelling from the decode logic to the output register
    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic                eos;
    } result_t;

endpackage

### rtl/core/utf8_mapped_char_to_byte_unit.sv
// Top level of the mapped UTF-8 to raw byte decoder.
//
// Takes the UTF-8 bytes of one vocabulary string, one byte per beat, with
// last_of_string marking the final byte, and returns the raw bytes the
// string stands for. One byte can be accepted every cycle while results are
// taken. A byte goes into the input register when it is accepted; the byte
// then waits there until the result register is free, and its result goes
// through the decode and map logic into the result register, from which it
// is offered on the output channel. A lead byte opens a 1 to 4 byte
// sequence; continuation bytes are not checked, only their low six bits are
// kept. Lead and middle bytes give no result, the byte that finishes a code
// point gives one. Code points 0x21..0x7E, 0xA1..0xAC and 0xAE..0xFF map to
// themselves, 256..323 map in order to the hidden bytes 0x00..0x20,
// 0x7F..0xA0 and 0xAD; anything else gives status 1 (skipped). A bad lead
// byte gives status 2 and the rest of that string is dropped without
// results; a string that ends inside a sequence gives status 3 with
// end_of_string set. out_byte is zero for every non-ok status. On any error
// the consumer should discard the whole string. While the result register
// is full and stalled, the input register holds its byte, even one that
// makes no result, and byte_stall is raised; the input takes one beat into
// an empty input register and then waits.
module utf8_mapped_char_to_byte_unit
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [u8cb_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              last_of_string,

    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [u8cb_pkg::BYTE_W-1:0]       out_byte,
    output logic [u8cb_pkg::STATUS_W-1:0]     status,
    output logic                              end_of_string
);

    // Input register
    logic                              s1_valid_reg;
    logic [u8cb_pkg::BYTE_W-1:0]       s1_byte_reg;
    logic                              s1_last_reg;

    // Sequence state
    logic [u8cb_pkg::NEED_W-1:0]       need_reg;
    logic [u8cb_pkg::NEED_W-1:0]       need_next;
    logic [u8cb_pkg::CP_W-1:0]         acc_reg;
    logic [u8cb_pkg::CP_W-1:0]         acc_next;
    logic                              drop_reg;
    logic                              drop_next;

    // Output register
    u8cb_pkg::result_t                 out_reg;
    u8cb_pkg::result_t                 res;

    logic                              out_free;
    logic                              s1_adv;
    logic [u8cb_pkg::CP_W-1:0]         acc_shift;
    logic [u8cb_pkg::NEED_W-1:0]       need_dec;
    logic [u8cb_pkg::CP_W-1:0]         map_cp;
    logic [u8cb_pkg::BYTE_W-1:0]       map_byte;
    logic                              map_unknown;

    // The output register can take a new result when empty or draining
    assign out_free   = !out_reg.valid || !result_stall;
    assign s1_adv     = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;

    assign acc_shift = {acc_reg[u8cb_pkg::CP_W-7:0], s1_byte_reg[5:0]};
    assign need_dec  = need_reg - 1'b1;

    // Inside a sequence map the gathered code point, else the byte itself
    assign map_cp = (need_reg != '0) ? acc_shift
                                     : {{(u8cb_pkg::CP_W-u8cb_pkg::BYTE_W){1'b0}}, s1_byte_reg};

    u8cb_map u_map
    (
        .code_point (map_cp),
        .raw_byte   (map_byte),
        .unknown    (map_unknown)
    );

    // Decode one byte: next sequence state and the optional result
    always_comb
    begin
        need_next  = need_reg;
        acc_next   = acc_reg;
        drop_next  = drop_reg;
        res.valid  = 1'b0;
        res.data   = '0;
        res.status = u8cb_pkg::ST_OK;
        res.eos    = s1_last_reg;

        if (drop_reg)
        begin
            // Swallow the rest of a failed string, start fresh after its end
            if (s1_last_reg)
            begin
                need_next = '0;
                acc_next  = '0;
                drop_next = 1'b0;
            end
        end
        else if (need_reg != '0)
        begin
            if (need_dec == '0)
            begin
                need_next  = '0;
                acc_next   = '0;
                res.valid  = 1'b1;
                res.data   = map_byte;
                res.status = map_unknown ? u8cb_pkg::ST_SKIP : u8cb_pkg::ST_OK;
            end
            else if (s1_last_reg)
            begin
                need_next  = '0;
                acc_next   = '0;
                res.valid  = 1'b1;
                res.status = u8cb_pkg::ST_TRUNCATED;
                res.eos    = 1'b1;
            end
            else
            begin
                need_next = need_dec;
                acc_next  = acc_shift;
            end
        end
        else if (!s1_byte_reg[7])
        begin
            res.valid  = 1'b1;
            res.data   = map_byte;
            res.status = map_unknown ? u8cb_pkg::ST_SKIP : u8cb_pkg::ST_OK;
        end
        else if ((s1_byte_reg & u8cb_pkg::LEAD4_MASK) != u8cb_pkg::LEAD4_PAT &&
                 (s1_byte_reg & u8cb_pkg::LEAD3_MASK) != u8cb_pkg::LEAD3_PAT &&
                 (s1_byte_reg & u8cb_pkg::LEAD2_MASK) != u8cb_pkg::LEAD2_PAT)
        begin
            // Bad lead byte: report it and drop the rest of the string
            need_next  = '0;
            acc_next   = '0;
            drop_next  = !s1_last_reg;
            res.valid  = 1'b1;
            res.status = u8cb_pkg::ST_BAD_LEAD;
        end
        else if (s1_last_reg)
        begin
            // Valid lead on the last byte: the sequence cannot finish
            need_next  = '0;
            acc_next   = '0;
            res.valid  = 1'b1;
            res.status = u8cb_pkg::ST_TRUNCATED;
            res.eos    = 1'b1;
        end
        else if ((s1_byte_reg & u8cb_pkg::LEAD2_MASK) == u8cb_pkg::LEAD2_PAT)
        begin
            need_next = 2'd1;
            acc_next  = {{(u8cb_pkg::CP_W-5){1'b0}}, s1_byte_reg[4:0]};
        end
        else if ((s1_byte_reg & u8cb_pkg::LEAD3_MASK) == u8cb_pkg::LEAD3_PAT)
        begin
            need_next = 2'd2;
            acc_next  = {{(u8cb_pkg::CP_W-4){1'b0}}, s1_byte_reg[3:0]};
        end
        else
        begin
            need_next = 2'd3;
            acc_next  = {{(u8cb_pkg::CP_W-3){1'b0}}, s1_byte_reg[2:0]};
        end
    end

    // Input register: load on an accepted beat, empty when it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            s1_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= last_of_string;
        end
    end

    // Sequence state: advance once per decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= '0;
            acc_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            need_reg <= need_next;
            acc_reg  <= acc_next;
            drop_reg <= drop_next;
        end
    end

    // Output register: hold while stalled, refill from decode when free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (out_free)
        begin
            out_reg.valid <= s1_adv && res.valid;
            if (s1_adv && res.valid)
            begin
                out_reg.data   <= res.data;
                out_reg.status <= res.status;
                out_reg.eos    <= res.eos;
            end
        end
    end

    assign result_valid  = out_reg.valid;
    assign out_byte      = out_reg.data;
    assign status        = out_reg.status;
    assign end_of_string = out_reg.eos;

`ifndef SYNTHESIS
    a_err_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != u8cb_pkg::ST_OK |-> out_byte == '0)
        else $error("non-ok result carries a nonzero byte");

    a_trunc_eos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == u8cb_pkg::ST_TRUNCATED |-> end_of_string)
        else $error("truncated result without end of string");

    a_drop_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> need_reg == '0)
        else $error("dropping while a sequence is open");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !byte_stall)
        else $error("empty input register stalls the input");

    a_bad_lead_drops: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && res.valid && res.status == u8cb_pkg::ST_BAD_LEAD && !s1_last_reg
        |=> drop_reg)
        else $error("bad lead byte did not start dropping");
`endif

endmodule

### rtl/core/u8cb_map.sv
// Code point to raw byte map of the byte-level vocabulary alphabet.
module u8cb_map
(
    input  logic [u8cb_pkg::CP_W-1:0]   code_point,
    output logic [u8cb_pkg::BYTE_W-1:0] raw_byte,
    output logic                        unknown
);

    logic                            printable;
    logic                            hidden;
    logic [u8cb_pkg::HIDDEN_W-1:0]   hidden_idx;
    logic [u8cb_pkg::BYTE_W-1:0]     hidden_byte;

    assign printable =
        (code_point >= u8cb_pkg::PRINT_A_LO && code_point <= u8cb_pkg::PRINT_A_HI) ||
        (code_point >= u8cb_pkg::PRINT_B_LO && code_point <= u8cb_pkg::PRINT_B_HI) ||
        (code_point >= u8cb_pkg::PRINT_C_LO && code_point <= u8cb_pkg::PRINT_C_HI);

    assign hidden = (code_point >= u8cb_pkg::HIDDEN_BASE) &&
                    (code_point <  u8cb_pkg::HIDDEN_END);

    // Offset from the hidden base fits the low bits
    assign hidden_idx = code_point[u8cb_pkg::HIDDEN_W-1:0];

    always_comb
    begin
        if (hidden_idx < u8cb_pkg::HIDDEN_LOW_N)
        begin
            hidden_byte = {1'b0, hidden_idx};
        end
        else if (hidden_idx < u8cb_pkg::HIDDEN_MID_N)
        begin
            hidden_byte = {1'b0, hidden_idx} + u8cb_pkg::HIDDEN_MID_OFS;
        end
        else
        begin
            hidden_byte = u8cb_pkg::HIDDEN_SHY;
        end
    end

    always_comb
    begin
        if (printable)
        begin
            raw_byte = code_point[u8cb_pkg::BYTE_W-1:0];
            unknown  = 1'b0;
        end
        else if (hidden)
        begin
            raw_byte = hidden_byte;
            unknown  = 1'b0;
        end
        else
        begin
            raw_byte = '0;
            unknown  = 1'b1;
        end
    end

endmodule

### tb/tb_top.sv
// Testbench for the mapped UTF-8 to raw byte decoder: directed and random strings, self-checked.
`timescale 1ns / 1ps

module tb_top;

    // Results pass through the input and result registers behind the byte that makes them; leave some margin.
    localparam int DRAIN_CYCLES   = 8;
    // Longest quiet stretch allowed: sender gaps and receiver stalls stay far below this.
    localparam int WATCHDOG_LIMIT = 2000;

    // One decoded result as it should appear on the output channel.
    typedef struct packed {
        logic [u8cb_pkg::BYTE_W-1:0]   raw;
        logic [u8cb_pkg::STATUS_W-1:0] code;
        logic                          eos;
    } raw_byte_t;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_TOGGLE} stall_style_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          byte_valid;
    logic                          byte_stall;
    logic [u8cb_pkg::BYTE_W-1:0]   in_byte;
    logic                          last_of_string;
    logic                          result_valid;
    logic                          result_stall;
    logic [u8cb_pkg::BYTE_W-1:0]   out_byte;
    logic [u8cb_pkg::STATUS_W-1:0] status;
    logic                          end_of_string;

    // Decoder state as this bench sees it.
    logic [u8cb_pkg::NEED_W-1:0]   cont_left;
    logic [u8cb_pkg::CP_W-1:0]     partial_cp;
    logic                          skip_to_eos;

    raw_byte_t                     pending_raw_bytes[$];
    int                            mismatch_count = 0;
    int                            bytes_sent     = 0;

    // Sender burst shaping
    logic                          sender_idles;
    int                            burst_left     = 0;
    int                            longest_gap    = 1;

    // Receiver stall pattern
    stall_style_t                  stall_style    = STALL_NONE;
    int                            style_left     = 0;
    int                            stall_run      = 0;

    int                            quiet_cycles   = 0;

    utf8_mapped_char_to_byte_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .in_byte        (in_byte),
        .last_of_string (last_of_string),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .out_byte       (out_byte),
        .status         (status),
        .end_of_string  (end_of_string)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Turn a code point back into the raw byte it stands for. Printable
    // code points map to themselves; 256..323 walk through the hidden bytes
    // 0x00..0x20, then 0x7F..0xA0, then the soft hyphen 0xAD.
    function automatic logic [u8cb_pkg::STATUS_W-1:0] unmap_code_point(
        input  logic [u8cb_pkg::CP_W-1:0]   cp,
        output logic [u8cb_pkg::BYTE_W-1:0] raw);
        logic [u8cb_pkg::CP_W-1:0] idx;
        raw = '0;
        if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
            (cp >= 21'hAE && cp <= 21'hFF))
        begin
            raw = cp[u8cb_pkg::BYTE_W-1:0];
            return u8cb_pkg::ST_OK;
        end
        if (cp >= 21'd256 && cp < 21'd324)
        begin
            idx = cp - 21'd256;
            if (idx < 21'd33)
                raw = idx[u8cb_pkg::BYTE_W-1:0];
            else if (idx < 21'd67)
                raw = 8'h7F + (idx[u8cb_pkg::BYTE_W-1:0] - 8'd33);
            else
                raw = 8'hAD;
            return u8cb_pkg::ST_OK;
        end
        return u8cb_pkg::ST_SKIP;
    endfunction

    function void reset_decode_state();
        cont_left   = '0;
        partial_cp  = '0;
        skip_to_eos = 1'b0;
    endfunction

    // Append one expected result behind the ones already waiting.
    function void queue_result(input raw_byte_t r);
        pending_raw_bytes.insert(pending_raw_bytes.size(), r);
    endfunction

    // Advance the decoder state by one accepted beat and queue the result it makes.
    function void decode_mapped_byte(input logic [u8cb_pkg::BYTE_W-1:0] b, input logic last);
        raw_byte_t r;
        r.raw  = '0;
        r.code = u8cb_pkg::ST_OK;
        r.eos  = last;

        // Rest of a string after a bad lead: swallow silently up to its end.
        if (skip_to_eos)
        begin
            if (last)
                reset_decode_state();
            return;
        end

        // Continuation byte: top two bits are not checked, only the payload is kept.
        if (cont_left != '0)
        begin
            partial_cp = {partial_cp[u8cb_pkg::CP_W-7:0], b[5:0]};
            cont_left  = cont_left - 1'b1;
            if (cont_left == '0)
            begin
                r.code     = unmap_code_point(partial_cp, r.raw);
                partial_cp = '0;
                queue_result(r);
            end
            else if (last)
            begin
                reset_decode_state();
                r.code = u8cb_pkg::ST_TRUNCATED;
                queue_result(r);
            end
            return;
        end

        // Lead position
        if (!b[7])
        begin
            r.code = unmap_code_point({13'd0, b}, r.raw);
            queue_result(r);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            partial_cp = {16'd0, b[4:0]};
            cont_left  = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            partial_cp = {17'd0, b[3:0]};
            cont_left  = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            partial_cp = {18'd0, b[2:0]};
            cont_left  = 2'd3;
        end
        else
        begin
            reset_decode_state();
            skip_to_eos = !last;
            r.code      = u8cb_pkg::ST_BAD_LEAD;
            queue_result(r);
            return;
        end
        // A lead on the final byte leaves the sequence cut short.
        if (last)
        begin
            reset_decode_state();
            r.code = u8cb_pkg::ST_TRUNCATED;
            queue_result(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Drive one beat, hold it until the block takes it, then maybe idle a while.
    task automatic push_byte(input logic [u8cb_pkg::BYTE_W-1:0] b, input logic last);
        int gap;
        byte_valid     <= 1'b1;
        in_byte        <= b;
        last_of_string <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        decode_mapped_byte(b, last);
        bytes_sent++;
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, longest_gap);
                burst_left = $urandom_range(1, 16);
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Encode a code point in n bytes and send the first keep of them. Mark the
    // last beat sent when last is set. Continuation tags are mostly 2'b10 but
    // sometimes garbage, since the block only masks them.
    task automatic push_code_point(input logic [u8cb_pkg::CP_W-1:0] cp, input int n,
                                   input int keep, input logic last);
        logic [u8cb_pkg::BYTE_W-1:0] seq [4];
        logic [1:0]                  tag;
        int                          i;
        case (n)
            1:       seq[0] = {1'b0, cp[6:0]};
            2:       seq[0] = {3'b110, cp[10:6]};
            3:       seq[0] = {4'b1110, cp[15:12]};
            default: seq[0] = {5'b11110, cp[20:18]};
        endcase
        for (i = 1; i < n; i++)
        begin
            tag    = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'b10;
            seq[i] = {tag, cp[6*(n-1-i) +: 6]};
        end
        for (i = 0; i < keep; i++)
            push_byte(seq[i], last && (i == keep - 1));
    endtask

    // One character: weighted toward the mapped ranges, with unknown code
    // points of every length and an occasional overlong encoding.
    task automatic push_random_char(input logic last);
        logic [u8cb_pkg::CP_W-1:0] cp;
        int                        n;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                cp = 21'($urandom_range(8'h21, 8'h7E));
                n  = 1;
            end
            3:
            begin
                cp = 21'($urandom_range(0, 127));
                n  = 1;
            end
            4, 5:
            begin
                cp = 21'($urandom_range(256, 323));
                n  = 2;
            end
            6:
            begin
                cp = 21'($urandom_range(128, 255));
                n  = 2;
            end
            7:
            begin
                cp = 21'($urandom_range(0, 11'h7FF));
                n  = 2;
            end
            8:
            begin
                cp = 21'($urandom_range(0, 16'hFFFF));
                n  = 3;
            end
            default:
            begin
                cp = 21'($urandom);
                n  = 4;
            end
        endcase
        if (n < 4 && $urandom_range(0, 15) == 0)
            n++;
        push_code_point(cp, n, n, last);
    endtask

    // One string of a few elements. A broken string mixes in raw noise,
    // sequences cut short and bad leads.
    task automatic push_string(input logic broken);
        int   count;
        int   j;
        int   n;
        logic last;
        count = $urandom_range(1, broken ? 6 : 8);
        for (j = 0; j < count; j++)
        begin
            last = (j == count - 1);
            if (!broken)
                push_random_char(last);
            else
                case ($urandom_range(0, 3))
                    0: push_byte(8'($urandom), last);
                    1: push_random_char(last);
                    2:
                    begin
                        n = $urandom_range(2, 4);
                        push_code_point(21'($urandom), n, $urandom_range(1, n - 1), last);
                    end
                    default:
                        push_byte($urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                                       : {5'b11111, 3'($urandom)}, last);
                endcase
        end
    endtask

    // Drop valid and wait out every expected result plus the pipeline.
    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_raw_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        sender_idles = 1'b1;
        longest_gap  = 3;
        push_byte(8'h00, 1'b1);                           // code point 0: skipped
        push_byte(8'h7F, 1'b1);                           // DEL is hidden: skipped
        push_byte(8'h21, 1'b0);                           // printable edges
        push_byte(8'h7E, 1'b1);
        push_byte(8'hC4, 1'b0); push_byte(8'h80, 1'b0);   // 256 -> 0x00
        push_byte(8'hC5, 1'b0); push_byte(8'h83, 1'b0);   // 323 -> 0xAD
        push_byte(8'hC5, 1'b0); push_byte(8'h84, 1'b1);   // 324: skipped
        push_byte(8'hC3, 1'b0); push_byte(8'hBF, 1'b1);   // 0xFF maps to itself
        push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0);   // largest 4-byte code point
        push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b1);
        push_byte(8'h80, 1'b0);                           // bad lead before the end of its string:
        push_byte(8'h41, 1'b0); push_byte(8'hFF, 1'b1);   // ... rest is dropped
        push_byte(8'hFF, 1'b1);                           // bad lead on the final byte
        push_byte(8'hE0, 1'b0); push_byte(8'h80, 1'b1);   // string ends mid-sequence
        push_byte(8'hF0, 1'b1);                           // lead alone as final byte
        push_byte(8'hC2, 1'b0); push_byte(8'hA1, 1'b1);   // 0xA1 maps to itself
        drain_results();
    endtask

    task automatic test_well_formed_strings();
        int stop_at;
        sender_idles = 1'b1;
        longest_gap  = 12;
        stop_at      = bytes_sent + 700;
        while (bytes_sent < stop_at)
            push_string(1'b0);
        drain_results();
    endtask

    task automatic test_broken_strings();
        int stop_at;
        sender_idles = 1'b1;
        longest_gap  = 6;
        stop_at      = bytes_sent + 300;
        while (bytes_sent < stop_at)
            push_string(1'b1);
        drain_results();
    endtask

    // Full input rate, good and broken strings mixed.
    task automatic test_back_to_back_strings();
        int stop_at;
        sender_idles = 1'b0;
        stop_at      = bytes_sent + 300;
        while (bytes_sent < stop_at)
            push_string(1'($urandom_range(0, 1)));
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver stalls follow their own pattern: quiet stretches, sparse
    // random stalls, long runs and a strict toggle, each for a while.
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
            style_left  <= $urandom_range(32, 160);
        end
        else
            style_left <= style_left - 1;

        case (stall_style)
            STALL_NONE:   result_stall <= 1'b0;
            STALL_SPARSE: result_stall <= ($urandom_range(0, 2) == 0);
            STALL_RUNS:
            begin
                if (stall_run != 0)
                begin
                    result_stall <= 1'b1;
                    stall_run    <= stall_run - 1;
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    result_stall <= 1'b1;
                    stall_run    <= $urandom_range(1, 12);
                end
                else
                    result_stall <= 1'b0;
            end
            default:      result_stall <= ~result_stall;
        endcase
    end

    function void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        raw_byte_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_raw_bytes.size() == 0)
                log_mismatch($sformatf("unexpected result: byte %02h status %0d eos %0d",
                                       out_byte, status, end_of_string));
            else
            begin
                want = pending_raw_bytes.pop_front();
                if (out_byte !== want.raw || status !== want.code ||
                    end_of_string !== want.eos)
                    log_mismatch($sformatf(
                        "result mismatch: byte %02h/%02h status %0d/%0d eos %0d/%0d (exp/act)",
                        want.raw, out_byte, want.code, status, want.eos, end_of_string));
            end
        end
    end

    // Stop a hung run: count cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          <= 1'b0;
        byte_valid     <= 1'b0;
        in_byte        <= '0;
        last_of_string <= 1'b0;
        result_stall   <= 1'b0;
        sender_idles    = 1'b0;
        reset_decode_state();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_well_formed_strings();
        test_broken_strings();
        test_back_to_back_strings();

        if (mismatch_count == 0 && pending_raw_bytes.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
